[hdl/rstwr_pkg.sv]
package rstwr_pkg;

    // Table size and derived widths
    localparam int SLOTS       = 16;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Field widths fixed by the interface
    localparam int FUNC_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int SERIAL_W = 16;
    localparam int CT_W     = 3;
    localparam int EV_W     = 4;
    localparam int TRIES_W  = 8;

    localparam logic [TRIES_W-1:0] MAX_TRIES_RST = 8'd3;

    // Function codes carried on the input word
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEND    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESP    = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd4;

    // Call types
    localparam logic [CT_W-1:0] CT_SYN   = 3'd1;
    localparam logic [CT_W-1:0] CT_FUNC  = 3'd2;
    localparam logic [CT_W-1:0] CT_MSG   = 3'd3;
    localparam logic [CT_W-1:0] CT_NOACK = 3'd4;

    // Event codes
    localparam logic [EV_W-1:0] EV_GRANTED  = 4'd0;
    localparam logic [EV_W-1:0] EV_FULL     = 4'd1;
    localparam logic [EV_W-1:0] EV_TRANSMIT = 4'd2;
    localparam logic [EV_W-1:0] EV_REFUSED  = 4'd3;
    localparam logic [EV_W-1:0] EV_ACCEPTED = 4'd4;
    localparam logic [EV_W-1:0] EV_DROPPED  = 4'd5;
    localparam logic [EV_W-1:0] EV_TIMEOUT  = 4'd6;
    localparam logic [EV_W-1:0] EV_RELEASED = 4'd7;
    localparam logic [EV_W-1:0] EV_NOTFOUND = 4'd8;

    // Decoded operation handed from the front end to the engine
    typedef enum logic [2:0] {
        OP_ALLOC,
        OP_SEND,
        OP_RESP,
        OP_TICK,
        OP_RELEASE
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                in_range;
        logic [SLOT_W-1:0]   slot;
        logic [SERIAL_W-1:0] serial;
        logic [CT_W-1:0]     ct;
    } cmd_t;

    // One result word
    typedef struct packed {
        logic                last;
        logic                freed;
        logic [CT_W-1:0]     ct;
        logic [SERIAL_W-1:0] serial;
        logic [SLOT_W-1:0]   slot;
        logic [EV_W-1:0]     ev;
    } res_t;

    // One slot of the tracking table
    typedef struct packed {
        logic                used;
        logic [SERIAL_W-1:0] serial;
        logic [SERIAL_W-1:0] nser;
        logic [TRIES_W-1:0]  tries;
        logic [CT_W-1:0]     ct;
        logic                answered;
    } entry_t;

endpackage

[hdl/rstwr_front.sv]
module rstwr_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rstwr_pkg::FUNC_W-1:0]    in_func,
    input  logic [rstwr_pkg::SLOT_W-1:0]    in_slot,
    input  logic [rstwr_pkg::SERIAL_W-1:0]  in_serial,
    input  logic [rstwr_pkg::CT_W-1:0]      in_ct,
    output logic                            cmd_valid,
    input  logic                            cmd_pop,
    output rstwr_pkg::cmd_t                 cmd
);

    rstwr_pkg::cmd_t q_reg [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    rstwr_pkg::cmd_t dec;
    logic            known;
    logic            push;
    logic            pop;

    // Decode the function code; unused codes are dropped here
    always_comb
    begin
        dec          = '0;
        known        = 1'b1;
        dec.slot     = in_slot;
        dec.serial   = in_serial;
        dec.ct       = in_ct;
        dec.in_range = (32'(in_slot) < rstwr_pkg::SLOTS);
        unique case (in_func)
            rstwr_pkg::FUNC_ALLOC:   dec.op = rstwr_pkg::OP_ALLOC;
            rstwr_pkg::FUNC_SEND:    dec.op = rstwr_pkg::OP_SEND;
            rstwr_pkg::FUNC_RESP:    dec.op = rstwr_pkg::OP_RESP;
            rstwr_pkg::FUNC_TICK:    dec.op = rstwr_pkg::OP_TICK;
            rstwr_pkg::FUNC_RELEASE: dec.op = rstwr_pkg::OP_RELEASE;
            default:
            begin
                dec.op = rstwr_pkg::OP_ALLOC;
                known  = 1'b0;
            end
        endcase
    end

    // Two-entry command queue between the front end and the engine
    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready && known;
    assign pop       = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

[hdl/rstwr_engine.sv]
module rstwr_engine (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rstwr_pkg::TRIES_W-1:0]  cfg_wr_data,
    input  logic                           cmd_valid,
    output logic                           cmd_pop,
    input  rstwr_pkg::cmd_t                cmd,
    output logic                           res_valid,
    input  logic                           res_ready,
    output rstwr_pkg::res_t                res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_TOUT,
        S_FINISH
    } state_t;

    localparam logic [rstwr_pkg::IDX_W-1:0] LAST_IDX = rstwr_pkg::IDX_W'(rstwr_pkg::SLOTS - 1);

    state_t                               state_reg;
    rstwr_pkg::cmd_t                      cmd_reg;
    logic [rstwr_pkg::IDX_W-1:0]          idx_reg;
    logic [rstwr_pkg::CNT_W-1:0]          cnt_reg;
    rstwr_pkg::res_t                      held_reg;
    logic                                 held_vld_reg;
    logic [rstwr_pkg::TRIES_W-1:0]        max_tries_reg;
    rstwr_pkg::entry_t                    tbl_reg [rstwr_pkg::SLOTS];

    rstwr_pkg::entry_t                    cur;
    rstwr_pkg::entry_t                    ent_next;
    logic                                 ent_we;
    rstwr_pkg::res_t                      new_res;
    logic                                 emit_req;
    logic                                 emit_go;
    logic                                 slot_ok;
    logic                                 last_idx;
    logic                                 step;
    logic                                 done;
    logic                                 go_tout;
    logic                                 push_req;
    logic                                 stall;
    logic                                 spend;
    logic [rstwr_pkg::TRIES_W-1:0]        tries_after;

    assign cur      = tbl_reg[idx_reg];
    assign slot_ok  = cmd_reg.in_range && cur.used;
    assign last_idx = (idx_reg == LAST_IDX);

    // Work out what the current slot step does
    always_comb
    begin
        ent_next    = cur;
        ent_we      = 1'b0;
        new_res     = '0;
        emit_req    = 1'b0;
        step        = 1'b0;
        done        = 1'b0;
        go_tout     = 1'b0;
        spend       = (cur.tries != '0) && (cur.ct != rstwr_pkg::CT_NOACK);
        tries_after = spend ? (cur.tries - 8'd1) : cur.tries;

        if (state_reg == S_EXEC)
        begin
            unique case (cmd_reg.op)
                rstwr_pkg::OP_ALLOC:
                begin
                    if (!cur.used)
                    begin
                        ent_we            = 1'b1;
                        ent_next.used     = 1'b1;
                        ent_next.serial   = cur.nser;
                        ent_next.nser     = cur.nser + 16'd1;
                        ent_next.tries    = max_tries_reg;
                        ent_next.answered = 1'b0;
                        emit_req          = 1'b1;
                        new_res.ev        = rstwr_pkg::EV_GRANTED;
                        new_res.slot      = rstwr_pkg::SLOT_W'(idx_reg);
                        new_res.serial    = cur.nser;
                        new_res.ct        = cur.ct;
                        done              = 1'b1;
                    end
                    else if (last_idx)
                    begin
                        emit_req   = 1'b1;
                        new_res.ev = rstwr_pkg::EV_FULL;
                        done       = 1'b1;
                    end
                    else
                    begin
                        step = 1'b1;
                    end
                end
                rstwr_pkg::OP_SEND:
                begin
                    done         = 1'b1;
                    emit_req     = 1'b1;
                    new_res.slot = cmd_reg.slot;
                    if (!slot_ok)
                    begin
                        new_res.ev = rstwr_pkg::EV_REFUSED;
                    end
                    else
                    begin
                        ent_we         = 1'b1;
                        ent_next.ct    = cmd_reg.ct;
                        new_res.serial = cur.serial;
                        new_res.ct     = cmd_reg.ct;
                        if (cur.tries == '0)
                        begin
                            new_res.ev = rstwr_pkg::EV_REFUSED;
                        end
                        else
                        begin
                            ent_next.tries = cur.tries - 8'd1;
                            new_res.ev     = rstwr_pkg::EV_TRANSMIT;
                            if (cmd_reg.ct == rstwr_pkg::CT_NOACK)
                            begin
                                ent_next.used = 1'b0;
                                ent_next.ct   = '0;
                                new_res.freed = 1'b1;
                            end
                        end
                    end
                end
                rstwr_pkg::OP_RESP:
                begin
                    done         = 1'b1;
                    emit_req     = 1'b1;
                    new_res.slot = cmd_reg.slot;
                    if (slot_ok && (cur.serial == cmd_reg.serial) && !cur.answered)
                    begin
                        ent_we            = 1'b1;
                        ent_next.answered = 1'b1;
                        new_res.serial    = cur.serial;
                        new_res.ct        = cur.ct;
                        if ((cur.ct == rstwr_pkg::CT_SYN) || (cur.ct == rstwr_pkg::CT_MSG))
                        begin
                            new_res.ev = rstwr_pkg::EV_ACCEPTED;
                        end
                        else if (cur.ct == rstwr_pkg::CT_FUNC)
                        begin
                            ent_next.used = 1'b0;
                            ent_next.ct   = '0;
                            new_res.ev    = rstwr_pkg::EV_ACCEPTED;
                            new_res.freed = 1'b1;
                        end
                        else
                        begin
                            new_res.ev = rstwr_pkg::EV_DROPPED;
                        end
                    end
                    else
                    begin
                        new_res.ev     = rstwr_pkg::EV_DROPPED;
                        new_res.serial = cmd_reg.serial;
                    end
                end
                rstwr_pkg::OP_RELEASE:
                begin
                    done         = 1'b1;
                    emit_req     = 1'b1;
                    new_res.slot = cmd_reg.slot;
                    if (slot_ok)
                    begin
                        ent_we         = 1'b1;
                        ent_next.used  = 1'b0;
                        ent_next.ct    = '0;
                        new_res.ev     = rstwr_pkg::EV_RELEASED;
                        new_res.serial = cur.serial;
                        new_res.ct     = cur.ct;
                        new_res.freed  = 1'b1;
                    end
                    else
                    begin
                        new_res.ev = rstwr_pkg::EV_NOTFOUND;
                    end
                end
                rstwr_pkg::OP_TICK:
                begin
                    new_res.slot   = rstwr_pkg::SLOT_W'(idx_reg);
                    new_res.serial = cur.serial;
                    new_res.ct     = cur.ct;
                    if (!cur.used)
                    begin
                        step = 1'b1;
                    end
                    else
                    begin
                        ent_we         = 1'b1;
                        ent_next.tries = tries_after;
                        if (spend && (cur.tries != max_tries_reg))
                        begin
                            // Retransmit; a timeout may follow in the next step
                            emit_req   = 1'b1;
                            new_res.ev = rstwr_pkg::EV_TRANSMIT;
                            go_tout    = (tries_after == '0);
                            step       = (tries_after != '0);
                        end
                        else if (tries_after == '0)
                        begin
                            ent_next.used = 1'b0;
                            ent_next.ct   = '0;
                            emit_req      = 1'b1;
                            new_res.ev    = rstwr_pkg::EV_TIMEOUT;
                            new_res.freed = 1'b1;
                            step          = 1'b1;
                        end
                        else
                        begin
                            step = 1'b1;
                        end
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end
        else if (state_reg == S_TOUT)
        begin
            // Timeout that follows a final retransmit of the same slot
            ent_we         = 1'b1;
            ent_next.used  = 1'b0;
            ent_next.ct    = '0;
            emit_req       = 1'b1;
            new_res.ev     = rstwr_pkg::EV_TIMEOUT;
            new_res.slot   = rstwr_pkg::SLOT_W'(idx_reg);
            new_res.serial = cur.serial;
            new_res.ct     = cur.ct;
            new_res.freed  = 1'b1;
            step           = 1'b1;
        end
    end

    // The held word goes out when a newer one arrives, or with last set at the end
    assign emit_go   = emit_req && (cnt_reg < rstwr_pkg::CNT_W'(rstwr_pkg::MAX_RESULTS));
    assign push_req  = held_vld_reg && (emit_go || (state_reg == S_FINISH));
    assign stall     = push_req && !res_ready;
    assign res_valid = push_req;
    assign cmd_pop   = (state_reg == S_IDLE) && cmd_valid;

    always_comb
    begin
        res      = held_reg;
        res.last = (state_reg == S_FINISH);
    end

    // Sequencer, held result and configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_vld_reg  <= 1'b0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            max_tries_reg <= rstwr_pkg::MAX_TRIES_RST;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_tries_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cnt_reg <= '0;
                        if ((cmd.op == rstwr_pkg::OP_ALLOC) || (cmd.op == rstwr_pkg::OP_TICK))
                        begin
                            idx_reg <= '0;
                        end
                        else
                        begin
                            idx_reg <= rstwr_pkg::IDX_W'(cmd.slot);
                        end
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC, S_TOUT:
                begin
                    if (!stall)
                    begin
                        if (emit_go)
                        begin
                            held_vld_reg <= 1'b1;
                            cnt_reg      <= cnt_reg + rstwr_pkg::CNT_W'(1);
                        end
                        if (done || (step && last_idx))
                        begin
                            state_reg <= S_FINISH;
                        end
                        else if (go_tout)
                        begin
                            state_reg <= S_TOUT;
                        end
                        else if (step)
                        begin
                            idx_reg   <= idx_reg + rstwr_pkg::IDX_W'(1);
                            state_reg <= S_EXEC;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (!held_vld_reg || res_ready)
                    begin
                        held_vld_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Payload registers: command and held result word
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        if (!stall && emit_go)
        begin
            held_reg <= new_res;
        end
    end

    // Slot table, written at the walking index only
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rstwr_pkg::SLOTS; i++)
            begin
                tbl_reg[i] <= '0;
            end
        end
        else if (ent_we && !stall)
        begin
            tbl_reg[idx_reg] <= ent_next;
        end
    end

endmodule

[hdl/rstwr_out_fifo.sv]
module rstwr_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rstwr_pkg::res_t in_word,
    output logic            out_valid,
    input  logic            out_ready,
    output rstwr_pkg::res_t out_word
);

    rstwr_pkg::res_t q_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;
    logic            push;
    logic            pop;

    // Two-entry result queue that parts the engine from the output bus
    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_word  = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

[hdl/request_slot_tracker_with_retry_top.sv]
// A result word passes the front end's command queue, the engine's command and held
// result registers and the output queue. The engine takes a new command only when idle;
// an allocate walks the slots up to the first free one and a tick walks every slot,
// with an extra timeout step for each slot that both retransmits and times out.
// Reset (rst_n, asynchronous, active low) clears every slot and sets max_tries to 3.
module request_slot_tracker_with_retry_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] slot, [19:4] serial_number, [22:20] call_type, [23] zero
    input  logic [23:0] s_axis_tdata,
    // [2:0] func
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] out_slot, [19:4] out_serial, [22:20] out_call_type, [23] slot_freed
    output logic [23:0] m_axis_tdata,
    // [3:0] event_res
    output logic [3:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic            cmd_valid;
    logic            cmd_pop;
    rstwr_pkg::cmd_t cmd;
    logic            res_valid;
    logic            res_ready;
    rstwr_pkg::res_t res;
    rstwr_pkg::res_t out_word;

    // Front end: decode and queue commands
    rstwr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_slot   (s_axis_tdata[3:0]),
        .in_serial (s_axis_tdata[19:4]),
        .in_ct     (s_axis_tdata[22:20]),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // Back end: slot table and sequencer
    rstwr_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Result queue towards the output bus
    rstwr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_word   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (out_word)
    );

    assign m_axis_tdata = {out_word.freed, out_word.ct, out_word.serial, out_word.slot};
    assign m_axis_tuser = out_word.ev;
    assign m_axis_tlast = out_word.last;

endmodule

[hdl/rstwr_checker.sv]
module rstwr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result word holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // Only defined event codes leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= rstwr_pkg::EV_NOTFOUND))
        else $error("undefined event code");

    // Timeouts and releases always free their slot
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == rstwr_pkg::EV_TIMEOUT)
            || (m_axis_tuser == rstwr_pkg::EV_RELEASED)) |-> m_axis_tdata[23])
        else $error("timeout or release without freed flag");

    // Single-answer events are final and never free a slot
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == rstwr_pkg::EV_GRANTED)
            || (m_axis_tuser == rstwr_pkg::EV_FULL)
            || (m_axis_tuser == rstwr_pkg::EV_REFUSED)
            || (m_axis_tuser == rstwr_pkg::EV_NOTFOUND))
            |-> m_axis_tlast && !m_axis_tdata[23])
        else $error("single-answer event not final or freed a slot");

endmodule

bind request_slot_tracker_with_retry_top rstwr_checker u_rstwr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
